FILE: src/fts_pkg.sv
// Shared types and constants of the fan tachometer speed meter.
// Used by the channels, the configuration block and the top level.
package fts_pkg;

	localparam int CNT_W      = 16;
	localparam int RPM_W      = 20;
	localparam int SCALE_W    = 26;
	localparam int NUM_W      = CNT_W + SCALE_W;
	localparam int EPR_W      = 5;
	localparam int MIN_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Microseconds per minute: turns edges per microsecond into rpm.
	localparam logic [SCALE_W-1:0] RPM_SCALE = SCALE_W'(60000000);
	localparam logic [RPM_W-1:0]   RPM_MAX   = '1;
	localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

	localparam logic [MIN_W-1:0] MIN_INTERVAL_RST = MIN_W'(2000);
	localparam logic [EPR_W-1:0] EDGES_PER_REV_RST = EPR_W'(4);

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGES_PER_REV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TACHO_ENABLED = 2'd2;

	localparam logic FUNC_EDGE = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic [MIN_W-1:0] min_interval;
		logic [EPR_W-1:0] edges_per_rev;
		logic             tacho_enabled;
	} fts_cfg_t;

endpackage

FILE: src/fts_if.sv
// Valid/ready channels of the fan tachometer speed meter.
// Depends on fts_pkg for the result field widths.
interface fts_in_if #(parameter int TIME_BITS = 48);
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic                 fan;
	logic [TIME_BITS-1:0] time_us;

	modport source (output valid, func, fan, time_us, input ready);
	modport sink (input valid, func, fan, time_us, output ready);
endinterface

interface fts_out_if;
	logic                       valid;
	logic                       ready;
	logic                       fan_out;
	logic [fts_pkg::RPM_W-1:0]  fan_speed;

	modport source (output valid, fan_out, fan_speed, input ready);
	modport sink (input valid, fan_out, fan_speed, output ready);
endinterface

FILE: src/fts_cfg.sv
// Configuration registers of the fan tachometer speed meter.
// Depends on fts_pkg for the register indexes and the fts_cfg_t type.
module fts_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [fts_pkg::CFG_IDX_W-1:0]    index,
	input  logic [fts_pkg::CFG_DATA_W-1:0]   data,
	output fts_pkg::fts_cfg_t                cfg
);

	fts_pkg::fts_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval  <= fts_pkg::MIN_INTERVAL_RST;
			cfg_q.edges_per_rev <= fts_pkg::EDGES_PER_REV_RST;
			cfg_q.tacho_enabled <= 1'b1;
		end else if (wr_en) begin
			case (index)
				fts_pkg::CFG_MIN_INTERVAL: begin
					cfg_q.min_interval <= data[fts_pkg::MIN_W-1:0];
				end
				fts_pkg::CFG_EDGES_PER_REV: begin
					cfg_q.edges_per_rev <= data[fts_pkg::EPR_W-1:0];
				end
				fts_pkg::CFG_TACHO_ENABLED: begin
					cfg_q.tacho_enabled <= data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/fts_div.sv
// Bit-serial restoring divider with a saturated quotient.
// One numerator bit per cycle through a single subtractor; no package use.
module fts_div #(
	parameter int NW = 42,
	parameter int DW = 53,
	parameter int QW = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quot
);

	localparam int CW = (NW > 1) ? $clog2(NW) : 1;

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] quot_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	// Shift the next numerator bit into the partial remainder and try the divisor.
	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				quot_q <= '0;
				ovf_q  <= 1'b0;
				cnt_q  <= CW'(NW - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q  <= {num_q[NW-2:0], 1'b0};
				rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				quot_q <= {quot_q[QW-2:0], ge};
				// A one shifted past the top quotient bit means the result saturates.
				ovf_q  <= ovf_q | quot_q[QW-1];
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = ovf_q ? '1 : quot_q;

endmodule

FILE: src/fan_tacho_speed_meter.sv
// Fan tachometer speed meter: top level with the item sequencer and per-fan state.
// Depends on fts_pkg, the fts_in_if/fts_out_if channels, fts_cfg and fts_div.
//
// Each word on the item channel is a tacho edge or a speed read for one fan. An edge
// counts when tacho counting is enabled and more than min_interval microseconds has
// passed since that fan's last counted edge; it gives no result and passes through
// S_EDGE before the next word is taken, unless it is dropped for a disabled tacho or
// an out-of-range fan index. A read reports count*60000000/(edges_per_rev*elapsed)
// rpm, saturated to 20 bits, then clears the count and stores the read time. A read
// puts its result word out when the bit-serial divider, which retires one of the 42
// numerator bits per cycle, is done, and the next word can be taken once that word
// is out; a read with no counted edges, zero elapsed time or an out-of-range fan
// index skips the divider. A finished result that finds the output register still
// full waits there, and the block takes nothing until it moves in. The block takes
// one word at a time; a result in the output register does not hold up the next word.
// Counts saturate at 65535, and all time differences are taken modulo 2^TIME_BITS.
module fan_tacho_speed_meter #(
	parameter int NUM_FANS  = 2,
	parameter int TIME_BITS = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	fts_in_if.sink                           item,
	fts_out_if.source                        result,
	input  logic                             cfg_wr_en,
	input  logic [fts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fts_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int FIW = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;
	localparam int NW  = fts_pkg::NUM_W;
	localparam int DW  = TIME_BITS + fts_pkg::EPR_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EDGE,
		S_PREP,
		S_DIV,
		S_FINISH
	} state_t;

	fts_pkg::fts_cfg_t cfg;

	state_t                   state_q;
	logic                     fan_q;
	logic [TIME_BITS-1:0]     t_q;
	logic [fts_pkg::RPM_W-1:0] rpm_q;
	logic                     res_valid_q;
	logic                     res_fan_q;
	logic [fts_pkg::RPM_W-1:0] res_rpm_q;

	logic [TIME_BITS-1:0]     last_edge_q [NUM_FANS];
	logic [TIME_BITS-1:0]     last_read_q [NUM_FANS];
	logic [fts_pkg::CNT_W-1:0] count_q    [NUM_FANS];

	logic [FIW-1:0]            fan_idx;
	logic [TIME_BITS-1:0]      ref_time;
	logic [TIME_BITS-1:0]      elapsed;
	logic                      edge_ok;
	logic [fts_pkg::CNT_W-1:0] count_cur;
	logic [fts_pkg::EPR_W-1:0] epr_eff;
	logic [NW-1:0]             num_prod;
	logic [DW-1:0]             den_prod;
	logic                      item_fan_ok;
	logic                      accept;
	logic                      div_start;
	logic                      div_done;
	logic [fts_pkg::RPM_W-1:0] div_quot;

	fts_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign fan_idx   = FIW'(fan_q);
	// One subtractor serves both the edge gap and the read interval.
	assign ref_time  = (state_q == S_EDGE) ? last_edge_q[fan_idx] : last_read_q[fan_idx];
	assign elapsed   = t_q - ref_time;
	assign edge_ok   = elapsed > TIME_BITS'(cfg.min_interval);
	assign count_cur = count_q[fan_idx];
	assign epr_eff   = (cfg.edges_per_rev == '0) ? fts_pkg::EPR_W'(1) : cfg.edges_per_rev;
	assign num_prod  = NW'(count_cur) * NW'(fts_pkg::RPM_SCALE);
	assign den_prod  = DW'(epr_eff) * DW'(elapsed);

	assign item_fan_ok = (32'(item.fan) < NUM_FANS);
	assign item.ready  = (state_q == S_IDLE);
	assign accept      = item.valid && item.ready;

	assign div_start = (state_q == S_PREP) && (count_cur != '0) && (elapsed != '0);

	fts_div #(
		.NW (NW),
		.DW (DW),
		.QW (fts_pkg::RPM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_prod),
		.den    (den_prod),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fan_q       <= 1'b0;
			t_q         <= '0;
			rpm_q       <= '0;
			res_valid_q <= 1'b0;
			res_fan_q   <= 1'b0;
			res_rpm_q   <= '0;
		end else begin
			if ((state_q == S_FINISH) && (!res_valid_q || result.ready)) begin
				res_valid_q <= 1'b1;
				res_fan_q   <= fan_q;
				res_rpm_q   <= rpm_q;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						fan_q <= item.fan;
						t_q   <= item.time_us;
						if (item.func == fts_pkg::FUNC_EDGE) begin
							if (item_fan_ok && cfg.tacho_enabled) begin
								state_q <= S_EDGE;
							end
						end else if (item_fan_ok) begin
							state_q <= S_PREP;
						end else begin
							rpm_q   <= '0;
							state_q <= S_FINISH;
						end
					end
				end
				S_EDGE: begin
					state_q <= S_IDLE;
				end
				S_PREP: begin
					if (count_cur == '0) begin
						rpm_q   <= '0;
						state_q <= S_FINISH;
					end else if (elapsed == '0) begin
						rpm_q   <= fts_pkg::RPM_MAX;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						rpm_q   <= div_quot;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!res_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FANS; i++) begin
				last_edge_q[i] <= '0;
				last_read_q[i] <= '0;
				count_q[i]     <= '0;
			end
		end else begin
			if ((state_q == S_EDGE) && edge_ok) begin
				last_edge_q[fan_idx] <= t_q;
				if (count_cur != fts_pkg::CNT_MAX) begin
					count_q[fan_idx] <= count_cur + 1'b1;
				end
			end
			// The divider holds its own copies of the operands, so the read can clear now.
			if (state_q == S_PREP) begin
				count_q[fan_idx]     <= '0;
				last_read_q[fan_idx] <= t_q;
			end
		end
	end

	assign result.valid     = res_valid_q;
	assign result.fan_out   = res_fan_q;
	assign result.fan_speed = res_rpm_q;

endmodule
